@@ design/rmpb_pkg.sv @@
// ----------------------------------------------------------------------------
// rmpb_pkg: shared types and constants for the RGB map paint/blend core
// Field widths, opcode, status and register codes, sequencer states and
// the channel combine and clamp functions.
// ----------------------------------------------------------------------------
package rmpb_pkg;

	localparam int CFG_W   = 9;    // map_width / map_height
	localparam int COORD_W = 11;   // x_pos / z_pos, signed
	localparam int CH_W    = 8;    // one colour channel
	localparam int FACT_W  = 10;   // blend factor, unsigned Q2.8
	localparam int OPC_W   = 3;
	localparam int STAT_W  = 2;
	localparam int OFFS_W  = 16;   // buffer_offset
	localparam int PIX_W   = 3 * CH_W;

	localparam int PDATA_W = 32;
	localparam int PADDR_W = 3;

	// shared multiply-add: acc = a * b + c
	localparam int MAC_A_W = 12;
	localparam int MAC_W   = 25;

	// floor(n / 3) == (n * 683) >> 11 for every n in 0..765
	localparam int GREY_MUL   = 683;
	localparam int GREY_SHIFT = 11;
	localparam int BLEND_SH   = 8;
	localparam int CH_MAX     = 255;

	typedef enum logic [OPC_W-1:0] {
		OP_SUB     = 3'd0,
		OP_REPLACE = 3'd1,
		OP_ADD     = 3'd2,
		OP_GREY    = 3'd3,
		OP_BLEND   = 3'd4,
		OP_KEEP    = 3'd5
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OUTSIDE = 2'd0,
		STAT_NO_DISP = 2'd1,
		STAT_OK      = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_AREA,
		ST_OFF,
		ST_DISP,
		ST_CHECK,
		ST_READ,
		ST_BR,
		ST_BG,
		ST_BB,
		ST_WB
	} state_t;

	typedef struct packed {
		logic                      en;
		logic signed [MAC_A_W-1:0] a;
		logic signed [MAC_A_W-1:0] b;
		logic signed [MAC_W-1:0]   c;
	} mac_req_t;

	// blend accumulator -> floored shift -> clamp to 0..255
	function automatic logic [CH_W-1:0] clamp_blend(input logic signed [MAC_W-1:0] acc);
		logic signed [MAC_W-1:0] sh;
		sh = acc >>> BLEND_SH;
		if (sh < 0)
			return '0;
		else if (sh > CH_MAX)
			return CH_W'(CH_MAX);
		else
			return sh[CH_W-1:0];
	endfunction

	// per-channel combine for one opcode, clamped
	function automatic logic [CH_W-1:0] chan_mix(
		input logic [OPC_W-1:0] op,
		input logic [CH_W-1:0]  old_v,
		input logic [CH_W-1:0]  new_v,
		input logic [CH_W-1:0]  grey_v,
		input logic [CH_W-1:0]  blend_v
	);
		logic signed [CH_W+1:0] v;
		logic signed [CH_W+1:0] o;
		logic signed [CH_W+1:0] n;
		o = $signed({2'b00, old_v});
		n = $signed({2'b00, new_v});
		case (op)
			OP_SUB:     v = o - n;
			OP_REPLACE: v = n;
			OP_ADD:     v = o + n;
			OP_GREY:    v = $signed({2'b00, grey_v}) + n;
			OP_BLEND:   v = $signed({2'b00, blend_v});
			default:    v = o;  // keep, and the unused codes
		endcase
		if (v < 0)
			return '0;
		else if (v > CH_MAX)
			return CH_W'(CH_MAX);
		else
			return v[CH_W-1:0];
	endfunction

endpackage

@@ design/rmpb_if.sv @@
// ----------------------------------------------------------------------------
// rmpb_if: valid/ready channels of the RGB map paint/blend core
// Paint request channel and result channel, each with source and sink sides.
// ----------------------------------------------------------------------------
interface rmpb_in_if import rmpb_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OPC_W-1:0]          opcode;
	logic signed [COORD_W-1:0] x_pos;
	logic signed [COORD_W-1:0] z_pos;
	logic [CH_W-1:0]           new_red;
	logic [CH_W-1:0]           new_green;
	logic [CH_W-1:0]           new_blue;
	logic [FACT_W-1:0]         blend_factor;

	modport source (
		output valid, opcode, x_pos, z_pos, new_red, new_green, new_blue, blend_factor,
		input  ready
	);
	modport sink (
		input  valid, opcode, x_pos, z_pos, new_red, new_green, new_blue, blend_factor,
		output ready
	);
endinterface

interface rmpb_out_if import rmpb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [OFFS_W-1:0] buffer_offset;
	logic [CH_W-1:0]   out_red;
	logic [CH_W-1:0]   out_green;
	logic [CH_W-1:0]   out_blue;

	modport source (
		output valid, status, buffer_offset, out_red, out_green, out_blue,
		input  ready
	);
	modport sink (
		input  valid, status, buffer_offset, out_red, out_green, out_blue,
		output ready
	);
endinterface

@@ design/rgb_map_paint_blend_core.sv @@
// ----------------------------------------------------------------------------
// rgb_map_paint_blend_core: paints one pixel of a row-flipped RGB map
// Read-modify-write of one in-map pixel per request transaction, one result per
// request, map dimensions set over an APB-style register port.
// ----------------------------------------------------------------------------
// Each request transaction names a pixel (x_pos, z_pos, row counted from the
// top), a brush colour, a blend factor and an opcode. The pixel lives at store
// offset (h-z-1)*w+x; outside 0..w*h-1 nothing is written and a result of
// status 0 with all-zero fields is returned. Otherwise the stored colour is
// combined (subtract, replace, add, grey plus colour, blend, keep; codes 6 and
// 7 keep), clamped to 0..255, written back and returned with the display
// offset z*w+x (status 2) or offset 0 when that lies outside the map
// (status 1). Sequencing: one multiply-add unit does all the arithmetic (map
// area, both offsets, the grey divide-by-three and the three blend channels)
// under a small sequencer, which takes no new request until the transaction
// is done; an off-map one ends after the offset check. The result sits in an
// output register, so the next request is taken while it waits. After reset
// the store is zeroed by a clearing pass over all MAX_WIDTH*MAX_HEIGHT
// entries (65536 with the defaults), during which no request is taken;
// register writes are accepted throughout.
// Registers: 0x0 map_width, 0x4 map_height (9 bits each, reset 256; zero acts
// as 1, values above MAX_WIDTH / MAX_HEIGHT saturate).
// ----------------------------------------------------------------------------
module rgb_map_paint_blend_core import rmpb_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	rmpb_in_if.sink             pix_in,
	rmpb_out_if.source          pix_out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// ---------------- register port ----------------
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(256);
			height_q <= CFG_W'(256);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	// effective dimensions: 0 reads as 1, large values saturate
	logic [CFG_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;

	always_comb begin
		if (width_q == '0)
			w_eff = CFG_W'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = CFG_W'(MAX_WIDTH);
		else
			w_eff = width_q;

		if (height_q == '0)
			h_eff = CFG_W'(1);
		else if (32'(height_q) > MAX_HEIGHT)
			h_eff = CFG_W'(MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// ---------------- request capture ----------------
	logic [OPC_W-1:0]          op_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] z_q;
	logic [CH_W-1:0]           nr_q;
	logic [CH_W-1:0]           ng_q;
	logic [CH_W-1:0]           nb_q;
	logic [FACT_W-1:0]         f_q;
	logic                      in_acc;

	assign in_acc = pix_in.valid & pix_in.ready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q <= pix_in.opcode;
			x_q  <= pix_in.x_pos;
			z_q  <= pix_in.z_pos;
			nr_q <= pix_in.new_red;
			ng_q <= pix_in.new_green;
			nb_q <= pix_in.new_blue;
			f_q  <= pix_in.blend_factor;
		end
	end

	// ---------------- shared multiply-add ----------------
	mac_req_t                mac_req;
	logic signed [MAC_W-1:0] acc;

	rmpb_mac u_mac (
		.clk (clk),
		.req (mac_req),
		.acc (acc)
	);

	// ---------------- pixel store ----------------
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [PIX_W-1:0]  mem_wdata;
	logic [PIX_W-1:0]  mem_rdata;

	rmpb_pixmem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	logic [CH_W-1:0] old_r;
	logic [CH_W-1:0] old_g;
	logic [CH_W-1:0] old_b;

	assign old_r = mem_rdata[3*CH_W-1:2*CH_W];
	assign old_g = mem_rdata[2*CH_W-1:CH_W];
	assign old_b = mem_rdata[CH_W-1:0];

	// ---------------- datapath registers ----------------
	state_t                  state_q;
	state_t                  state_d;
	logic [ADDR_W-1:0]       clr_q;
	logic signed [MAC_W-1:0] area_q;
	logic signed [MAC_W-1:0] off_q;
	logic signed [MAC_W-1:0] disp_q;
	logic [CH_W-1:0]         grey_q;
	logic [CH_W-1:0]         blr_q;
	logic [CH_W-1:0]         blg_q;

	logic off_ok;
	logic disp_ok;

	assign off_ok  = !off_q[MAC_W-1]  && (off_q  < area_q);
	assign disp_ok = !disp_q[MAC_W-1] && (disp_q < area_q);

	// sign/zero-extended operands for the multiply-add
	logic signed [MAC_A_W-1:0] w_a;
	logic signed [MAC_A_W-1:0] h_a;
	logic signed [MAC_A_W-1:0] z_a;
	logic signed [MAC_W-1:0]   x_c;
	logic [CH_W+1:0]           ch_sum;

	assign w_a    = $signed(MAC_A_W'(w_eff));
	assign h_a    = $signed(MAC_A_W'(h_eff));
	assign z_a    = MAC_A_W'(z_q);
	assign x_c    = MAC_W'(x_q);
	assign ch_sum = (CH_W+2)'(old_r) + (CH_W+2)'(old_g) + (CH_W+2)'(old_b);

	// final colours, valid in the write-back state
	logic [CH_W-1:0] fin_r;
	logic [CH_W-1:0] fin_g;
	logic [CH_W-1:0] fin_b;

	assign fin_r = chan_mix(op_q, old_r, nr_q, grey_q, blr_q);
	assign fin_g = chan_mix(op_q, old_g, ng_q, grey_q, blg_q);
	assign fin_b = chan_mix(op_q, old_b, nb_q, grey_q, clamp_blend(acc));

	// ---------------- output register ----------------
	logic              out_valid_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [OFFS_W-1:0] out_offs_q;
	logic [CH_W-1:0]   out_r_q;
	logic [CH_W-1:0]   out_g_q;
	logic [CH_W-1:0]   out_b_q;
	logic              out_free;
	logic              out_load;
	logic              out_hit;    // load from the write-back, else off-map zeros

	assign out_free = !out_valid_q || pix_out.ready;

	// blend operand for one channel: (new - old) * f + old * 256
	function automatic mac_req_t blend_req(
		input logic [CH_W-1:0]   old_v,
		input logic [CH_W-1:0]   new_v,
		input logic [FACT_W-1:0] fac
	);
		mac_req_t r;
		r.en = 1'b1;
		r.a  = $signed(MAC_A_W'(new_v)) - $signed(MAC_A_W'(old_v));
		r.b  = $signed(MAC_A_W'(fac));
		r.c  = $signed(MAC_W'({old_v, {BLEND_SH{1'b0}}}));
		return r;
	endfunction

	// ---------------- sequencer ----------------
	always_comb begin
		state_d      = state_q;
		mac_req      = '0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_addr     = off_q[ADDR_W-1:0];
		mem_wdata    = {fin_r, fin_g, fin_b};
		out_load     = 1'b0;
		out_hit      = 1'b0;
		pix_in.ready = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				// zero one entry a cycle until the whole store is done
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
				if (clr_q == ADDR_W'(DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				pix_in.ready = 1'b1;
				if (pix_in.valid)
					state_d = ST_AREA;
			end
			ST_AREA: begin
				mac_req.en = 1'b1;
				mac_req.a  = w_a;
				mac_req.b  = h_a;
				state_d    = ST_OFF;
			end
			ST_OFF: begin
				// flipped store offset (h - z - 1) * w + x
				mac_req.en = 1'b1;
				mac_req.a  = h_a - z_a - $signed(MAC_A_W'(1));
				mac_req.b  = w_a;
				mac_req.c  = x_c;
				state_d    = ST_DISP;
			end
			ST_DISP: begin
				// display offset z * w + x
				mac_req.en = 1'b1;
				mac_req.a  = z_a;
				mac_req.b  = w_a;
				mac_req.c  = x_c;
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				if (off_ok) begin
					mem_re  = 1'b1;
					state_d = ST_READ;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_READ: begin
				// grey = (r + g + b) / 3 by reciprocal
				mac_req.en = 1'b1;
				mac_req.a  = $signed(MAC_A_W'(ch_sum));
				mac_req.b  = $signed(MAC_A_W'(GREY_MUL));
				state_d    = ST_BR;
			end
			ST_BR: begin
				mac_req = blend_req(old_r, nr_q, f_q);
				state_d = ST_BG;
			end
			ST_BG: begin
				mac_req = blend_req(old_g, ng_q, f_q);
				state_d = ST_BB;
			end
			ST_BB: begin
				mac_req = blend_req(old_b, nb_q, f_q);
				state_d = ST_WB;
			end
			ST_WB: begin
				if (out_free) begin
					mem_we   = 1'b1;
					out_load = 1'b1;
					out_hit  = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// capture the multiply-add result of the previous step
	always_ff @(posedge clk) begin
		case (state_q)
			ST_OFF:   area_q <= acc;
			ST_DISP:  off_q  <= acc;
			ST_CHECK: disp_q <= acc;
			ST_BR:    grey_q <= acc[GREY_SHIFT+CH_W-1:GREY_SHIFT];
			ST_BG:    blr_q  <= clamp_blend(acc);
			ST_BB:    blg_q  <= clamp_blend(acc);
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (out_hit) begin
				out_stat_q <= disp_ok ? STAT_OK : STAT_NO_DISP;
				out_offs_q <= disp_ok ? disp_q[OFFS_W-1:0] : '0;
				out_r_q    <= fin_r;
				out_g_q    <= fin_g;
				out_b_q    <= fin_b;
			end else begin
				out_stat_q <= STAT_OUTSIDE;
				out_offs_q <= '0;
				out_r_q    <= '0;
				out_g_q    <= '0;
				out_b_q    <= '0;
			end
		end
	end

	assign pix_out.valid         = out_valid_q;
	assign pix_out.status        = out_stat_q;
	assign pix_out.buffer_offset = out_offs_q;
	assign pix_out.out_red       = out_r_q;
	assign pix_out.out_green     = out_g_q;
	assign pix_out.out_blue      = out_b_q;

`ifndef SYNTHESIS
	// an accepted request always starts with the area step
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_AREA)
		else $error("request accepted but sequencer did not start");

	// a paint write-back only ever lands inside the map
	a_wb_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB && mem_we) |-> off_ok)
		else $error("pixel write outside the map");

	// an off-map result carries all-zero fields
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stat_q == STAT_OUTSIDE) |->
		(out_offs_q == '0 && out_r_q == '0 && out_g_q == '0 && out_b_q == '0))
		else $error("off-map result with non-zero fields");

	// no request is taken until the clearing pass is over
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !pix_in.ready)
		else $error("request taken during clearing pass");
`endif

endmodule

@@ design/rmpb_mac.sv @@
// ----------------------------------------------------------------------------
// rmpb_mac: shared signed multiply-add with registered result
// acc <= a * b + c when enabled; holds otherwise.
// ----------------------------------------------------------------------------
module rmpb_mac import rmpb_pkg::*; (
	input  logic                    clk,
	input  mac_req_t                req,
	output logic signed [MAC_W-1:0] acc
);

	logic signed [2*MAC_A_W-1:0] prod;

	assign prod = req.a * req.b;

	always_ff @(posedge clk) begin
		if (req.en) begin
			acc <= MAC_W'(prod) + req.c;
		end
	end

endmodule

@@ design/rmpb_pixmem.sv @@
// ----------------------------------------------------------------------------
// rmpb_pixmem: single-port pixel store
// One access a cycle, write or read; read data registered.
// ----------------------------------------------------------------------------
module rmpb_pixmem import rmpb_pkg::*; #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [PIX_W-1:0]  wdata,
	output logic [PIX_W-1:0]  rdata
);

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
